// ===== design/fbi_pkg.sv =====
package fbi_pkg;

    // Width of the blend step register and of the phase counter (1 to 64).
    localparam int STEP_W = 7;
    localparam int PIX_W = 8;
    localparam int IDX_W = 16;
    localparam int PHASE_W = 6;
    // Numerator of one blend, at most 255 * 64.
    localparam int NUM_W = 14;
    // Number of divider stages; each stage resolves two quotient bits.
    localparam int DIV_STAGES = 4;

    localparam logic [STEP_W-1:0] RESET_STEPS = 7'd10;
    localparam logic [STEP_W-1:0] MAX_STEPS = 7'd64;

    // Side information that travels with each blend through the pipeline.
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [PHASE_W-1:0] phase;
        logic               last;
    } t_tag;

endpackage

// ===== design/fbi_seq.sv =====
module fbi_seq #(
    parameter int FRAME_BYTES = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [fbi_pkg::STEP_W-1:0]   i_steps,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [fbi_pkg::PIX_W-1:0]    i_pixel,
    input  logic [fbi_pkg::IDX_W-1:0]    i_idx,
    input  logic                         i_eof,
    output logic                         o_valid,
    output logic [fbi_pkg::PIX_W-1:0]    o_prev,
    output logic [fbi_pkg::PIX_W-1:0]    o_cur,
    output logic [fbi_pkg::IDX_W-1:0]    o_idx,
    output logic [fbi_pkg::STEP_W-1:0]   o_p,
    output logic [fbi_pkg::STEP_W-1:0]   o_n
);

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    logic [fbi_pkg::PIX_W-1:0]  r_mem [FRAME_BYTES];
    logic [fbi_pkg::PIX_W-1:0]  r_rdata;
    logic                       r_have_prev;
    logic                       r_valid;
    logic                       r_in_store;
    logic [fbi_pkg::PIX_W-1:0]  r_cur;
    logic [fbi_pkg::IDX_W-1:0]  r_idx;
    logic [fbi_pkg::STEP_W-1:0] r_p;
    logic [fbi_pkg::STEP_W-1:0] r_n;

    logic [AW+fbi_pkg::IDX_W-1:0] w_wide;
    logic [AW-1:0]                w_addr;
    logic                         w_in_store;
    logic                         w_accept;
    logic                         w_final;

    assign w_wide     = (AW + fbi_pkg::IDX_W)'(i_idx);
    assign w_addr     = w_wide[AW-1:0];
    assign w_in_store = 32'(i_idx) < 32'(FRAME_BYTES);
    assign w_final    = r_p == r_n;
    assign o_ready    = !r_valid || (i_en && w_final);
    assign w_accept   = i_valid && o_ready;

    // Read happens before the write of the same edge, so a byte sees the old value.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= r_mem[w_addr];
            if (w_in_store) begin
                r_mem[w_addr] <= i_pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_have_prev <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                if (i_eof) begin
                    r_have_prev <= 1'b1;
                end
            end else if (i_en && w_final) begin
                r_valid <= 1'b0;
            end
        end
    end

    // While the first frame passes through, the store holds nothing yet, so the
    // previous byte is forced to zero; its weight is zero then in any case.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur      <= i_pixel;
            r_idx      <= i_idx;
            r_in_store <= w_in_store && r_have_prev;
            r_p        <= 7'd1;
            r_n        <= r_have_prev ? i_steps : 7'd1;
        end else if (r_valid && i_en && !w_final) begin
            r_p <= r_p + 7'd1;
        end
    end

    assign o_valid = r_valid;
    assign o_prev  = r_in_store ? r_rdata : 8'd0;
    assign o_cur   = r_cur;
    assign o_idx   = r_idx;
    assign o_p     = r_p;
    assign o_n     = r_n;

endmodule

// ===== design/fbi_mul.sv =====
module fbi_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [fbi_pkg::PIX_W-1:0]   i_prev,
    input  logic [fbi_pkg::PIX_W-1:0]   i_cur,
    input  logic [fbi_pkg::IDX_W-1:0]   i_idx,
    input  logic [fbi_pkg::STEP_W-1:0]  i_p,
    input  logic [fbi_pkg::STEP_W-1:0]  i_n,
    output logic                        o_valid,
    output logic [fbi_pkg::NUM_W-1:0]   o_num,
    output logic [fbi_pkg::STEP_W-1:0]  o_n,
    output fbi_pkg::t_tag               o_tag
);

    logic                       r_v1;
    logic                       r_v2;
    logic [fbi_pkg::NUM_W-1:0]  r_a;
    logic [fbi_pkg::NUM_W-1:0]  r_b;
    logic [fbi_pkg::STEP_W-1:0] r_n1;
    logic [fbi_pkg::STEP_W-1:0] r_n2;
    fbi_pkg::t_tag              r_tag1;
    fbi_pkg::t_tag              r_tag2;
    logic [fbi_pkg::NUM_W-1:0]  r_num;

    logic [fbi_pkg::STEP_W-1:0] w_weight;
    fbi_pkg::t_tag              n_tag;

    assign w_weight = i_n - i_p;

    always_comb begin
        n_tag.idx   = i_idx;
        n_tag.phase = fbi_pkg::PHASE_W'(i_p - 7'd1);
        n_tag.last  = i_p == i_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one forms both weighted terms, stage two adds them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= fbi_pkg::NUM_W'(i_prev) * fbi_pkg::NUM_W'(w_weight);
            r_b    <= fbi_pkg::NUM_W'(i_cur) * fbi_pkg::NUM_W'(i_p);
            r_n1   <= i_n;
            r_tag1 <= n_tag;
            r_num  <= r_a + r_b;
            r_n2   <= r_n1;
            r_tag2 <= r_tag1;
        end
    end

    assign o_valid = r_v2;
    assign o_num   = r_num;
    assign o_n     = r_n2;
    assign o_tag   = r_tag2;

endmodule

// ===== design/fbi_div.sv =====
module fbi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [fbi_pkg::NUM_W-1:0]   i_num,
    input  logic [fbi_pkg::STEP_W-1:0]  i_n,
    input  fbi_pkg::t_tag               i_tag,
    output logic                        o_valid,
    output logic [fbi_pkg::PIX_W-1:0]   o_quot,
    output fbi_pkg::t_tag               o_tag
);

    localparam int S = fbi_pkg::DIV_STAGES;

    logic                       r_v   [S];
    logic [fbi_pkg::NUM_W-1:0]  r_rem [S];
    logic [fbi_pkg::PIX_W-1:0]  r_q   [S];
    logic [fbi_pkg::STEP_W-1:0] r_n   [S];
    fbi_pkg::t_tag              r_tag [S];

    logic                       in_v   [S];
    logic [fbi_pkg::NUM_W-1:0]  in_rem [S];
    logic [fbi_pkg::PIX_W-1:0]  in_q   [S];
    logic [fbi_pkg::STEP_W-1:0] in_n   [S];
    fbi_pkg::t_tag              in_tag [S];
    logic [fbi_pkg::NUM_W-1:0]  n_rem  [S];
    logic [fbi_pkg::PIX_W-1:0]  n_q    [S];

    genvar s;
    generate
        for (s = 0; s < S; s++) begin : g_stage
            if (s == 0) begin : g_first
                assign in_v[s]   = i_valid;
                assign in_rem[s] = i_num;
                assign in_q[s]   = '0;
                assign in_n[s]   = i_n;
                assign in_tag[s] = i_tag;
            end else begin : g_next
                assign in_v[s]   = r_v[s-1];
                assign in_rem[s] = r_rem[s-1];
                assign in_q[s]   = r_q[s-1];
                assign in_n[s]   = r_n[s-1];
                assign in_tag[s] = r_tag[s-1];
            end

            // Two restoring steps: quotient bits 7-2s and 6-2s.
            always_comb begin
                logic [fbi_pkg::NUM_W:0]   d1;
                logic [fbi_pkg::NUM_W:0]   d2;
                logic [fbi_pkg::NUM_W-1:0] rem1;
                logic                      b1;
                logic                      b2;
                d1   = (fbi_pkg::NUM_W + 1)'(in_n[s]) << (7 - 2 * s);
                d2   = (fbi_pkg::NUM_W + 1)'(in_n[s]) << (6 - 2 * s);
                b1   = {1'b0, in_rem[s]} >= d1;
                rem1 = b1 ? in_rem[s] - d1[fbi_pkg::NUM_W-1:0] : in_rem[s];
                b2   = {1'b0, rem1} >= d2;
                n_rem[s] = b2 ? rem1 - d2[fbi_pkg::NUM_W-1:0] : rem1;
                n_q[s]   = {in_q[s][fbi_pkg::PIX_W-3:0], b1, b2};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= in_v[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem[s];
                    r_q[s]   <= n_q[s];
                    r_n[s]   <= in_n[s];
                    r_tag[s] <= in_tag[s];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[S-1];
    assign o_quot  = r_q[S-1];
    assign o_tag   = r_tag[S-1];

endmodule

// ===== design/frame_blend_interpolator_top.sv =====
// The results of a byte pass through the sequencer register, the multiplier stages and the divider stages.
// A byte gives N results (N = blend_steps, clamped to 1..64), one a cycle while the output
// does not stall; the next byte is taken in the cycle its predecessor issues its last phase,
// so during the first frame (N = 1) one byte is taken per cycle while the output does not stall.
// Reset (synchronous, active low) clears the valid bits, the frame-seen flag and sets
// blend_steps to 10; the frame store has no reset and needs none.
module frame_blend_interpolator_top #(
    parameter int FRAME_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: blend_steps.
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] pixel_value, [23:8] byte_index
    input  logic        s_axis_tlast,  // end_of_frame
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] blended_value, [23:8] out_index
    output logic [5:0]  m_axis_tuser,  // [5:0] phase_number
    output logic        m_axis_tlast   // last_of_run
);

    logic [fbi_pkg::STEP_W-1:0] r_steps;
    logic [fbi_pkg::STEP_W-1:0] w_eff_steps;
    logic                       w_en;

    logic                       seq_valid;
    logic [fbi_pkg::PIX_W-1:0]  seq_prev;
    logic [fbi_pkg::PIX_W-1:0]  seq_cur;
    logic [fbi_pkg::IDX_W-1:0]  seq_idx;
    logic [fbi_pkg::STEP_W-1:0] seq_p;
    logic [fbi_pkg::STEP_W-1:0] seq_n;

    logic                       mul_valid;
    logic [fbi_pkg::NUM_W-1:0]  mul_num;
    logic [fbi_pkg::STEP_W-1:0] mul_n;
    fbi_pkg::t_tag              mul_tag;

    logic                       div_valid;
    logic [fbi_pkg::PIX_W-1:0]  div_quot;
    fbi_pkg::t_tag              div_tag;

    // The configuration register is to be written only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= fbi_pkg::RESET_STEPS;
        end else if (i_cfg_we) begin
            r_steps <= i_cfg_wdata;
        end
    end

    // A zero step count behaves as one, anything above the maximum saturates.
    always_comb begin
        if (r_steps == '0) begin
            w_eff_steps = 7'd1;
        end else if (r_steps > fbi_pkg::MAX_STEPS) begin
            w_eff_steps = fbi_pkg::MAX_STEPS;
        end else begin
            w_eff_steps = r_steps;
        end
    end

    // The pipeline holds when the final stage has a result that is not taken; only an
    // empty sequencer register still loads, so a stall neither drops nor repeats a transfer.
    assign w_en = !(div_valid && !m_axis_tready);

    // The sequencer reads the stored byte, writes the new one and issues one phase
    // per cycle while the pipeline is not stalled. During the first frame it issues a
    // single phase with N = 1, so the blend reduces to the current byte.
    fbi_seq #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_steps (w_eff_steps),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pixel (s_axis_tdata[7:0]),
        .i_idx   (s_axis_tdata[23:8]),
        .i_eof   (s_axis_tlast),
        .o_valid (seq_valid),
        .o_prev  (seq_prev),
        .o_cur   (seq_cur),
        .o_idx   (seq_idx),
        .o_p     (seq_p),
        .o_n     (seq_n)
    );

    // Two stages: the weighted terms, then their sum.
    fbi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (seq_valid),
        .i_prev  (seq_prev),
        .i_cur   (seq_cur),
        .i_idx   (seq_idx),
        .i_p     (seq_p),
        .i_n     (seq_n),
        .o_valid (mul_valid),
        .o_num   (mul_num),
        .o_n     (mul_n),
        .o_tag   (mul_tag)
    );

    // Four stages of restoring division by N; the last stage is the output register.
    fbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (mul_valid),
        .i_num   (mul_num),
        .i_n     (mul_n),
        .i_tag   (mul_tag),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .o_tag   (div_tag)
    );

    assign m_axis_tvalid = div_valid;
    assign m_axis_tdata  = {div_tag.idx, div_quot};
    assign m_axis_tuser  = div_tag.phase;
    assign m_axis_tlast  = div_tag.last;

endmodule

// ===== test/frame_blend_interpolator_top_tb.sv =====
module frame_blend_interpolator_top_tb;

    // Clock period is 12 time units, split into equal high and low halves.
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 7;
    localparam int STORE_BYTES = 65536;
    // Random transfers to send once the directed part is done.
    localparam int RANDOM_BYTES = 130;
    // Cycles to let pass after the last result before the block is called idle.
    localparam int SETTLE_CYCLES = 12;
    // A correct run needs far fewer cycles than this, even with 64 results per
    // byte and every result held up by the longest receiver stall.
    localparam int TIMEOUT_CYCLES = 1000000;

    // One byte of a frame, as it waits to be sent.
    typedef struct packed {
        logic [fbi_pkg::PIX_W-1:0] pixel;
        logic [fbi_pkg::IDX_W-1:0] idx;
        logic                      eof;
    } t_frame_byte;

    // One blended result, as the block should deliver it.
    typedef struct packed {
        logic [fbi_pkg::PIX_W-1:0]   value;
        logic [fbi_pkg::PHASE_W-1:0] phase;
        logic [fbi_pkg::IDX_W-1:0]   idx;
        logic                        last;
    } t_pixel_blend;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                       i_cfg_we = 1'b0;
    logic [fbi_pkg::STEP_W-1:0] i_cfg_wdata = '0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [7:0] pixel_value, [23:8] byte_index
    logic        s_axis_tlast = 1'b0; // end_of_frame

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [7:0] blended_value, [23:8] out_index
    logic [5:0]  m_axis_tuser;        // [5:0] phase_number
    logic        m_axis_tlast;        // last_of_run

    frame_blend_interpolator_top #(
        .FRAME_BYTES(STORE_BYTES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Bytes waiting to be sent, filled by the stimulus process.
    t_frame_byte  pending_bytes[$];
    // Blends that the block still owes us, oldest first.
    t_pixel_blend expected_blends[$];

    // Our own copy of the block state: the stored previous frame, whether a
    // frame has been completed, and the blend step register.
    logic [fbi_pkg::PIX_W-1:0]  frame_store [STORE_BYTES];
    bit                         frame_seen = 1'b0;
    logic [fbi_pkg::STEP_W-1:0] cfg_steps = fbi_pkg::RESET_STEPS;

    int mismatch_count = 0;

    // Step count as the block uses it: zero counts as one and anything above
    // the maximum is saturated.
    function automatic int effective_steps(logic [fbi_pkg::STEP_W-1:0] steps);
        if (steps == 0)
            return 1;
        if (steps > fbi_pkg::MAX_STEPS)
            return int'(fbi_pkg::MAX_STEPS);
        return int'(steps);
    endfunction

    // Works out every blend that one accepted byte gives and queues them. The
    // stored byte is read before the new one overwrites it.
    task automatic blend_byte(input logic [fbi_pkg::PIX_W-1:0] cur,
                              input logic [fbi_pkg::IDX_W-1:0] idx,
                              input logic eof);
        int n;
        int prev;
        t_pixel_blend blend;
        prev = int'(frame_store[idx]);
        if (!frame_seen) begin
            // While no frame has been completed the byte passes straight through.
            blend.value = cur;
            blend.phase = '0;
            blend.idx = idx;
            blend.last = 1'b1;
            expected_blends.push_back(blend);
        end else begin
            n = effective_steps(cfg_steps);
            for (int p = 1; p <= n; p++) begin
                blend.value = fbi_pkg::PIX_W'((prev * (n - p) + int'(cur) * p) / n);
                blend.phase = fbi_pkg::PHASE_W'(p - 1);
                blend.idx = idx;
                blend.last = (p == n);
                expected_blends.push_back(blend);
            end
        end
        frame_store[idx] = cur;
        if (eof)
            frame_seen = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Input driver. It sends in bursts of random length separated by random
    // gaps, and runs the prediction on every transfer it completes. Once
    // tvalid is raised it stays up until the block takes the byte.
    // ------------------------------------------------------------------
    int          burst_left = 1;
    int          gap_left = 0;
    t_frame_byte next_byte;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                blend_byte(s_axis_tdata[7:0], s_axis_tdata[23:8], s_axis_tlast);

            if (s_axis_tvalid && !s_axis_tready) begin
                // Stalled: hold the current byte as it is.
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                next_byte = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {next_byte.idx, next_byte.pixel};
                s_axis_tlast <= next_byte.eof;
                if (burst_left <= 1) begin
                    // End of a burst: mostly short gaps, sometimes none at all, now
                    // and then a long one that lets the output side run dry.
                    burst_left <= $urandom_range(1, 12);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left <= 0;
                        9:       gap_left <= $urandom_range(10, 30);
                        default: gap_left <= $urandom_range(1, 6);
                    endcase
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor. The ready line follows an 8-bit pattern that is reloaded
    // once all of its bits have been used: all ones for stretches without stalls,
    // random bits, or a sparse pattern that stalls for long spells.
    // ------------------------------------------------------------------
    logic [7:0]   ready_pattern = 8'hFF;
    int           ready_pos = 0;
    t_pixel_blend got_blend;

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_pos <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_blends.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %0d index %0d",
                             $time, m_axis_tdata[7:0], m_axis_tdata[23:8]);
                    mismatch_count++;
                end else begin
                    got_blend = expected_blends.pop_front();
                    check_field("blended_value", got_blend.value, m_axis_tdata[7:0]);
                    check_field("phase_number", got_blend.phase, m_axis_tuser);
                    check_field("out_index", got_blend.idx, m_axis_tdata[23:8]);
                    check_field("last_of_run", got_blend.last, m_axis_tlast);
                end
            end

            m_axis_tready <= ready_pattern[ready_pos];
            if (ready_pos == 7) begin
                ready_pos <= 0;
                case ($urandom_range(0, 3))
                    0, 3:    ready_pattern <= 8'hFF;
                    1:       ready_pattern <= 8'($urandom);
                    default: ready_pattern <= 8'($urandom & $urandom);
                endcase
            end else begin
                ready_pos <= ready_pos + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. Indices after the first frame are always taken from the
    // first frame's layout, so the block never blends with a store entry that
    // was never written.
    // ------------------------------------------------------------------
    logic [fbi_pkg::IDX_W-1:0] frame_layout[$];

    task automatic push_byte(input logic [fbi_pkg::PIX_W-1:0] pixel,
                             input logic [fbi_pkg::IDX_W-1:0] idx,
                             input logic eof);
        t_frame_byte b;
        b.pixel = pixel;
        b.idx = idx;
        b.eof = eof;
        pending_bytes.push_back(b);
    endtask

    function automatic logic [fbi_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return fbi_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Waits until every byte has been sent and every blend has come back, then
    // lets the block settle before it returns. Sampling on the falling edge keeps
    // clear of the updates made at the rising edge.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_blends.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register writes are only made while the block is idle.
    task automatic write_steps(input logic [fbi_pkg::STEP_W-1:0] steps);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= steps;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_steps = steps;
    endtask

    // Queues one frame and returns how many bytes it holds. A clean frame walks
    // the layout in order with end_of_frame on its last byte; a noisy one picks
    // layout entries at random and scatters end_of_frame.
    task automatic queue_frame(input bit clean, output int count);
        int len;
        if (clean) begin
            count = frame_layout.size();
            foreach (frame_layout[i])
                push_byte(random_pixel(), frame_layout[i], i == frame_layout.size() - 1);
        end else begin
            len = $urandom_range(1, 12);
            count = len;
            for (int i = 0; i < len; i++)
                push_byte(random_pixel(), frame_layout[$urandom_range(0, frame_layout.size() - 1)],
                          $urandom_range(0, 5) == 0);
        end
    endtask

    initial begin
        logic [fbi_pkg::PIX_W-1:0]  first_pixels[8];
        logic [fbi_pkg::STEP_W-1:0] steps;
        int random_sent;
        int frames;
        int sent;
        int phase_count;

        first_pixels = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h07};
        frame_layout = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
                         16'h5AA5, 16'hA55A, 16'hFFFF};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First frame: every byte passes through, the last one closes the frame.
        foreach (frame_layout[i])
            push_byte(first_pixels[i], frame_layout[i], i == frame_layout.size() - 1);
        // Second frame at the reset step count, with each byte flipped against
        // the first so that full-range blends in both directions show up.
        foreach (frame_layout[i])
            push_byte(~first_pixels[i], frame_layout[i], i == frame_layout.size() - 1);
        wait_drained();

        // A single step, the maximum, zero (taken as one) and all ones (saturated).
        write_steps(7'd1);
        push_byte(8'hFF, frame_layout[0], 1'b0);
        push_byte(8'h00, frame_layout[7], 1'b1);
        wait_drained();
        write_steps(fbi_pkg::MAX_STEPS);
        push_byte(8'h00, frame_layout[0], 1'b0);
        push_byte(8'hFF, frame_layout[7], 1'b1);
        wait_drained();
        write_steps(7'd0);
        push_byte(8'h80, frame_layout[5], 1'b0);
        wait_drained();
        write_steps(7'h7F);
        push_byte(8'h3C, frame_layout[6], 1'b1);
        wait_drained();

        // Random phases: a new step count, then a few frames. Large step counts
        // are rare and get a single frame to keep the run short.
        random_sent = 0;
        phase_count = 0;
        while (random_sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                6:       steps = $urandom_range(0, 1) ? fbi_pkg::MAX_STEPS : 7'h7F;
                7:       steps = 7'd0;
                8:       steps = fbi_pkg::STEP_W'($urandom_range(17, 127));
                9:       steps = 7'd1;
                default: steps = fbi_pkg::STEP_W'($urandom_range(1, 16));
            endcase
            write_steps(steps);
            frames = (effective_steps(steps) > 32) ? 1 : $urandom_range(2, 3);
            for (int f = 0; f < frames; f++) begin
                // In the first phase the sender holds off before the second frame until the
                // block has handed over every blend of the first frame.
                if (phase_count == 0 && f == 1)
                    wait_drained();
                queue_frame($urandom_range(0, 4) != 0, sent);
                random_sent += sent;
            end
            wait_drained();
            phase_count++;
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
